@@ design/psd_pkg.sv @@
// Shared types, widths and helpers for the point to segment distance block.
// Depends on nothing; psd_div, psd_sqrt and the top level import it.
package psd_pkg;

   localparam int COORD_W   = 32;  // Q16.16 coordinate word
   localparam int DIFF_W    = 33;  // difference of two coordinates
   localparam int PROD_W    = 66;  // product of two difference magnitudes
   localparam int SUM_W     = 68;  // sum of three products, with headroom
   localparam int T_BITS    = 30;  // fraction bits of the projection ratio
   localparam int Q_BITS    = 31;  // ratio bits: one integer plus T_BITS
   localparam int MRAW_W    = 64;  // magnitude times ratio
   localparam int ROOT_BITS = 35;  // square root result bits
   localparam int TRIAL_W   = 72;  // square root trial word

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [DIFF_W-1:0] mag_type;

   typedef enum logic [1:0] {
      KIND_INTERIOR = 2'd0,
      KIND_START    = 2'd1,
      KIND_END      = 2'd2
   } kind_type;

   // Data that rides alongside the divider.
   typedef struct packed {
      coord_type [2:0] s;
      coord_type [2:0] e;
      coord_type [2:0] p;
      logic      [2:0] d_neg;
      mag_type   [2:0] d_mag;
      kind_type        kind;
   } div_side_type;

   // Data that rides alongside the square root.
   typedef struct packed {
      coord_type [2:0] n;
      kind_type        kind;
   } root_side_type;

   function automatic mag_type mag33(input logic signed [DIFF_W-1:0] x);
      return x[DIFF_W-1] ? mag_type'(-x) : mag_type'(x);
   endfunction

endpackage

@@ design/psd_channels.sv @@
// Valid/ready channel interfaces for the point to segment distance block.
// Depends on nothing; used by the top level ports.
interface psd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] seg_start_x;
   logic signed [31:0] seg_start_y;
   logic signed [31:0] seg_start_z;
   logic signed [31:0] seg_end_x;
   logic signed [31:0] seg_end_y;
   logic signed [31:0] seg_end_z;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;

   modport source (output valid, seg_start_x, seg_start_y, seg_start_z,
                   seg_end_x, seg_end_y, seg_end_z, point_x, point_y, point_z,
                   input ready);
   modport sink (input valid, seg_start_x, seg_start_y, seg_start_z,
                 seg_end_x, seg_end_y, seg_end_z, point_x, point_y, point_z,
                 output ready);
endinterface

interface psd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] nearest_x;
   logic signed [31:0] nearest_y;
   logic signed [31:0] nearest_z;
   logic        [31:0] distance;
   logic        [1:0]  clamp_kind;
   logic               saturated;

   modport source (output valid, nearest_x, nearest_y, nearest_z, distance,
                   clamp_kind, saturated, input ready);
   modport sink (input valid, nearest_x, nearest_y, nearest_z, distance,
                 clamp_kind, saturated, output ready);
endinterface

@@ design/psd_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, side data carried.
// Depends on psd_pkg.
module psd_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [psd_pkg::SUM_W-1:0]    in_dividend,
   input  logic [psd_pkg::SUM_W-1:0]    in_divisor,
   input  psd_pkg::div_side_type        in_side,
   output logic                         out_valid,
   output logic [psd_pkg::Q_BITS-1:0]   out_quot,
   output psd_pkg::div_side_type        out_side
);
   import psd_pkg::*;

   logic              valid_ff [Q_BITS];
   logic [SUM_W-1:0]  rem_ff   [Q_BITS];
   logic [SUM_W-1:0]  dvs_ff   [Q_BITS];
   logic [Q_BITS-1:0] quot_ff  [Q_BITS];
   div_side_type      side_ff  [Q_BITS];

   genvar k;
   for (k = 0; k < Q_BITS; k++) begin : g_step
      logic              valid_prev;
      logic [SUM_W-1:0]  rem_prev, dvs_prev, trial, rem_in;
      logic [Q_BITS-1:0] quot_prev, quot_in;
      div_side_type      side_prev;
      logic              fits;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_dividend;
         assign dvs_prev   = in_divisor;
         assign quot_prev  = '0;
         assign side_prev  = in_side;
         // The integer bit compares without a shift.
         assign trial      = rem_prev;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign dvs_prev   = dvs_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign trial      = {rem_prev[SUM_W-2:0], 1'b0};
      end

      always_comb begin
         fits    = (trial >= dvs_prev);
         rem_in  = fits ? (trial - dvs_prev) : trial;
         quot_in = {quot_prev[Q_BITS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            dvs_ff[k]  <= dvs_prev;
            quot_ff[k] <= quot_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[Q_BITS-1];
   assign out_quot  = quot_ff[Q_BITS-1];
   assign out_side  = side_ff[Q_BITS-1];

endmodule

@@ design/psd_sqrt.sv @@
// Pipelined integer square root: one result bit per stage, side data carried.
// Depends on psd_pkg.
module psd_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [psd_pkg::SUM_W-1:0]      in_value,
   input  psd_pkg::root_side_type         in_side,
   output logic                           out_valid,
   output logic [psd_pkg::ROOT_BITS-1:0]  out_root,
   output psd_pkg::root_side_type         out_side
);
   import psd_pkg::*;

   logic                 valid_ff [ROOT_BITS];
   logic [SUM_W-1:0]     rem_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff  [ROOT_BITS];
   root_side_type        side_ff  [ROOT_BITS];

   genvar k;
   for (k = 0; k < ROOT_BITS; k++) begin : g_step
      localparam int B = ROOT_BITS - 1 - k;
      logic                 valid_prev;
      logic [SUM_W-1:0]     rem_prev, rem_in;
      logic [ROOT_BITS-1:0] root_prev, root_in;
      root_side_type        side_prev;
      logic [TRIAL_W-1:0]   trial, rem_wide;
      logic                 fits;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_value;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // The remainder holds value minus root squared; setting bit B adds
      // root * 2^(B+1) + 2^(2B) to the square.
      always_comb begin
         rem_wide = TRIAL_W'(rem_prev);
         trial    = (TRIAL_W'(root_prev) << (B + 1)) | (TRIAL_W'(1) << (2 * B));
         fits     = (rem_wide >= trial);
         rem_in   = fits ? SUM_W'(rem_wide - trial) : rem_prev;
         root_in  = root_prev;
         root_in[B] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule

@@ design/point_segment_distance.sv @@
// Top level of the point to segment distance block.
// Depends on psd_pkg, psd_channels, psd_div and psd_sqrt.
//
// Usage: each req_bus beat carries a segment (start, end) and a query point,
// all signed Q16.16. One rsp_bus beat comes back per request beat, in order,
// with the nearest point on the segment, which endpoint clamped it, and the
// Euclidean distance (saturating at all ones, flagged by saturated).
// For 2D work drive every z with zero.
// Throughput: one beat per cycle while rsp_bus keeps up. The pipeline
// holds 31 divider stages (one ratio bit each), 35 square root stages
// (one root bit each) and ten stages of products, sums and selects.
// Stalls: the whole pipeline advances on a common enable. When rsp_bus is
// not ready, the result waiting at the output holds and one more result
// moves into a skid register; only then does req_bus.ready drop, and it
// rises again the cycle after the waiting result is taken.
// Reset: synchronous, clears every valid bit, so the block comes out empty.
// A zero-length segment returns its start point, clamped to start.
module point_segment_distance (
   input logic         clock,
   input logic         reset,
   psd_req_if.sink     req_bus,
   psd_rsp_if.source   rsp_bus
);
   import psd_pkg::*;

   typedef struct packed {
      coord_type   x;
      coord_type   y;
      coord_type   z;
      logic [31:0] distance;
      kind_type    kind;
      logic        sat;
   } out_type;

   // Common pipeline enable; the skid register absorbs one beat.
   logic pipe_en;
   logic out_valid_ff, skid_valid_ff;
   out_type out_ff, skid_ff, last_data;

   assign pipe_en       = !skid_valid_ff;
   assign req_bus.ready = pipe_en;

   // Stage A: differences D = E - S and V = P - S.
   coord_type in_s [3], in_e [3], in_p [3];
   assign in_s[0] = req_bus.seg_start_x;
   assign in_s[1] = req_bus.seg_start_y;
   assign in_s[2] = req_bus.seg_start_z;
   assign in_e[0] = req_bus.seg_end_x;
   assign in_e[1] = req_bus.seg_end_y;
   assign in_e[2] = req_bus.seg_end_z;
   assign in_p[0] = req_bus.point_x;
   assign in_p[1] = req_bus.point_y;
   assign in_p[2] = req_bus.point_z;

   logic                     a_valid_ff;
   coord_type                a_s_ff [3], a_e_ff [3], a_p_ff [3];
   logic signed [DIFF_W-1:0] a_d_ff [3], a_v_ff [3], a_d_in [3], a_v_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_d_in[i] = {in_e[i][COORD_W-1], in_e[i]} - {in_s[i][COORD_W-1], in_s[i]};
         a_v_in[i] = {in_p[i][COORD_W-1], in_p[i]} - {in_s[i][COORD_W-1], in_s[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         a_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_s_ff <= in_s;
         a_e_ff <= in_e;
         a_p_ff <= in_p;
         a_d_ff <= a_d_in;
         a_v_ff <= a_v_in;
      end
   end

   // Stage B: magnitude products for V.D and D.D, with the sign of each term.
   logic              b_valid_ff;
   logic [PROD_W-1:0] b_vd_ff [3], b_dd_ff [3], b_vd_in [3], b_dd_in [3];
   logic [2:0]        b_vneg_ff, b_vneg_in;
   div_side_type      b_side_ff, b_side_in;
   mag_type           b_vm, b_dm;

   always_comb begin
      b_side_in = '0;
      b_vm = '0;
      b_dm = '0;
      for (int i = 0; i < 3; i++) begin
         b_vm = mag33(a_v_ff[i]);
         b_dm = mag33(a_d_ff[i]);
         b_vd_in[i]   = PROD_W'(b_vm) * PROD_W'(b_dm);
         b_dd_in[i]   = PROD_W'(b_dm) * PROD_W'(b_dm);
         b_vneg_in[i] = a_v_ff[i][DIFF_W-1] ^ a_d_ff[i][DIFF_W-1];
         b_side_in.s[i]     = a_s_ff[i];
         b_side_in.e[i]     = a_e_ff[i];
         b_side_in.p[i]     = a_p_ff[i];
         b_side_in.d_neg[i] = a_d_ff[i][DIFF_W-1];
         b_side_in.d_mag[i] = b_dm;
      end
      b_side_in.kind = KIND_INTERIOR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         b_vd_ff   <= b_vd_in;
         b_dd_ff   <= b_dd_in;
         b_vneg_ff <= b_vneg_in;
         b_side_ff <= b_side_in;
      end
   end

   // Stage C: positive and negative parts of the dot product, and len2.
   logic             c_valid_ff;
   logic [SUM_W-1:0] c_pos_ff, c_neg_ff, c_len2_ff, c_pos_in, c_neg_in, c_len2_in;
   div_side_type     c_side_ff;

   always_comb begin
      c_pos_in  = '0;
      c_neg_in  = '0;
      c_len2_in = '0;
      for (int i = 0; i < 3; i++) begin
         c_pos_in  = c_pos_in + (b_vneg_ff[i] ? '0 : SUM_W'(b_vd_ff[i]));
         c_neg_in  = c_neg_in + (b_vneg_ff[i] ? SUM_W'(b_vd_ff[i]) : '0);
         c_len2_in = c_len2_in + SUM_W'(b_dd_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         c_pos_ff  <= c_pos_in;
         c_neg_ff  <= c_neg_in;
         c_len2_ff <= c_len2_in;
         c_side_ff <= b_side_ff;
      end
   end

   // Stage DT: signed dot product.
   logic                  dt_valid_ff;
   logic signed [SUM_W:0] dt_dot_ff, dt_dot_in;
   logic [SUM_W-1:0]      dt_len2_ff;
   div_side_type          dt_side_ff;

   assign dt_dot_in = {1'b0, c_pos_ff} - {1'b0, c_neg_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         dt_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dt_dot_ff  <= dt_dot_in;
         dt_len2_ff <= c_len2_ff;
         dt_side_ff <= c_side_ff;
      end
   end

   // Clamp decision, made alongside the first divider step. A projection
   // that lands exactly on either end still counts as interior.
   div_side_type div_side_in, div_side;
   logic         div_valid;
   logic [Q_BITS-1:0] div_quot;

   always_comb begin
      div_side_in = dt_side_ff;
      if (dt_len2_ff == '0) begin
         div_side_in.kind = KIND_START;
      end else if (dt_dot_ff[SUM_W]) begin
         div_side_in.kind = KIND_START;
      end else if (dt_dot_ff[SUM_W-1:0] > dt_len2_ff) begin
         div_side_in.kind = KIND_END;
      end else begin
         div_side_in.kind = KIND_INTERIOR;
      end
   end

   psd_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .in_valid    (dt_valid_ff),
      .in_dividend (dt_dot_ff[SUM_W-1:0]),
      .in_divisor  (dt_len2_ff),
      .in_side     (div_side_in),
      .out_valid   (div_valid),
      .out_quot    (div_quot),
      .out_side    (div_side)
   );

   // Stage MR: |D_i| times the ratio t.
   logic              mr_valid_ff;
   logic [MRAW_W-1:0] mr_raw_ff [3], mr_raw_in [3];
   div_side_type      mr_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mr_raw_in[i] = MRAW_W'(div_side.d_mag[i]) * MRAW_W'(div_quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mr_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         mr_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mr_raw_ff  <= mr_raw_in;
         mr_side_ff <= div_side;
      end
   end

   // Stage NR: round the offset half away from zero and form the nearest point.
   logic                    nr_valid_ff;
   coord_type               nr_n_ff [3], nr_n_in [3], nr_p_ff [3];
   kind_type                nr_kind_ff;
   logic [MRAW_W-1:0]       nr_rnd;
   logic [DIFF_W-1:0]       nr_m;
   logic signed [DIFF_W:0]  nr_full;

   always_comb begin
      nr_rnd  = '0;
      nr_m    = '0;
      nr_full = '0;
      for (int i = 0; i < 3; i++) begin
         nr_rnd  = mr_raw_ff[i] + (MRAW_W'(1) << (T_BITS - 1));
         nr_m    = nr_rnd[T_BITS+DIFF_W-1:T_BITS];
         nr_full = mr_side_ff.d_neg[i]
                 ? ({{2{mr_side_ff.s[i][COORD_W-1]}}, mr_side_ff.s[i]} - {1'b0, nr_m})
                 : ({{2{mr_side_ff.s[i][COORD_W-1]}}, mr_side_ff.s[i]} + {1'b0, nr_m});
         case (mr_side_ff.kind)
            KIND_START: nr_n_in[i] = mr_side_ff.s[i];
            KIND_END:   nr_n_in[i] = mr_side_ff.e[i];
            default:    nr_n_in[i] = nr_full[COORD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         nr_valid_ff <= mr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         nr_n_ff    <= nr_n_in;
         nr_kind_ff <= mr_side_ff.kind;
         for (int i = 0; i < 3; i++) begin
            nr_p_ff[i] <= mr_side_ff.p[i];
         end
      end
   end

   // Stage DF: magnitude of P - nearest per axis.
   logic          df_valid_ff;
   mag_type       df_mag_ff [3], df_mag_in [3];
   root_side_type df_side_ff, df_side_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         df_mag_in[i] = mag33({nr_p_ff[i][COORD_W-1], nr_p_ff[i]}
                            - {nr_n_ff[i][COORD_W-1], nr_n_ff[i]});
         df_side_in.n[i] = nr_n_ff[i];
      end
      df_side_in.kind = nr_kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         df_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         df_valid_ff <= nr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         df_mag_ff  <= df_mag_in;
         df_side_ff <= df_side_in;
      end
   end

   // Stage SQ: squares.
   logic              sq_valid_ff;
   logic [PROD_W-1:0] sq_ff [3], sq_in [3];
   root_side_type     sq_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = PROD_W'(df_mag_ff[i]) * PROD_W'(df_mag_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         sq_valid_ff <= df_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq_ff      <= sq_in;
         sq_side_ff <= df_side_ff;
      end
   end

   // Stage SM: squared distance.
   logic             sm_valid_ff;
   logic [SUM_W-1:0] sm_sum_ff, sm_sum_in;
   root_side_type    sm_side_ff;

   assign sm_sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         sm_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sm_sum_ff  <= sm_sum_in;
         sm_side_ff <= sq_side_ff;
      end
   end

   logic                 root_valid;
   logic [ROOT_BITS-1:0] root;
   root_side_type        root_side;

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (sm_valid_ff),
      .in_value  (sm_sum_ff),
      .in_side   (sm_side_ff),
      .out_valid (root_valid),
      .out_root  (root),
      .out_side  (root_side)
   );

   // Final formatting: saturate the distance to 32 bits.
   always_comb begin
      last_data.x        = root_side.n[0];
      last_data.y        = root_side.n[1];
      last_data.z        = root_side.n[2];
      last_data.kind     = root_side.kind;
      last_data.sat      = |root[ROOT_BITS-1:COORD_W];
      last_data.distance = last_data.sat ? '1 : root[COORD_W-1:0];
   end

   // Output register plus skid register.
   logic push, taken;
   assign push  = pipe_en && root_valid;
   assign taken = out_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (taken) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (!out_valid_ff) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (taken) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= last_data;
         end
      end else if (!out_valid_ff) begin
         if (push) begin
            out_ff <= last_data;
         end
      end else if (push) begin
         skid_ff <= last_data;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.nearest_x  = out_ff.x;
   assign rsp_bus.nearest_y  = out_ff.y;
   assign rsp_bus.nearest_z  = out_ff.z;
   assign rsp_bus.distance   = out_ff.distance;
   assign rsp_bus.clamp_kind = out_ff.kind;
   assign rsp_bus.saturated  = out_ff.sat;

   // The skid register only ever holds a beat behind a waiting output beat.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // A finished beat arriving at a stalled output must land in the skid.
   a_stall_catches: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready && root_valid && !skid_valid_ff)
      |=> skid_valid_ff)
      else $error("result beat lost while output stalled");

   // A saturated distance always reads as all ones.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.saturated) |-> (rsp_bus.distance == '1))
      else $error("saturated beat without full-scale distance");

endmodule

@@ verif/psd_checker.sv @@
`timescale 1ns / 1ps
// Checker for the point to segment distance block: watches both channels,
// predicts each result from the accepted request beat and compares in order.
// Depends on psd_pkg and psd_channels.
module psd_checker (
   input  logic clock,
   input  logic reset,
   psd_req_if   req_mon,
   psd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   import psd_pkg::*;

   typedef struct packed {
      coord_type n_x;
      coord_type n_y;
      coord_type n_z;
      logic [31:0] distance;
      kind_type  kind;
      logic      sat;
   } nearest_result_type;

   nearest_result_type expected_results[$];

   assign pending_count = expected_results.size();

   function automatic logic [34:0] root_floor(input logic [127:0] sq);
      logic [34:0] r;
      logic [34:0] c;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         c = r | (35'd1 << b);
         if ({93'd0, c} * {93'd0, c} <= sq) r = c;
      end
      return r;
   endfunction

   function automatic nearest_result_type project_point(
      input coord_type s[3], input coord_type e[3], input coord_type p[3]);
      nearest_result_type res;
      logic signed [127:0] d[3], v[3], n[3], diff;
      logic signed [127:0] dot, len2, rem, m, dsq;
      logic [63:0] t;
      logic [34:0] root;
      kind_type kind;
      dot = 0;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = 128'(e[i]) - 128'(s[i]);
         v[i] = 128'(p[i]) - 128'(s[i]);
         dot += d[i] * v[i];
         len2 += d[i] * d[i];
      end
      kind = KIND_INTERIOR;
      if (len2 == 0 || dot < 0) begin
         kind = KIND_START;
         for (int i = 0; i < 3; i++) n[i] = s[i];
      end else if (dot > len2) begin
         kind = KIND_END;
         for (int i = 0; i < 3; i++) n[i] = e[i];
      end else begin
         // Ratio dot/len2 truncated to 30 fraction bits.
         t = 64'((dot <<< 30) / len2);
         for (int i = 0; i < 3; i++) begin
            m = ((d[i] < 0 ? -d[i] : d[i]) * $signed({64'd0, t}) + (128'sd1 <<< 29)) >>> 30;
            n[i] = d[i] < 0 ? 128'(s[i]) - m : 128'(s[i]) + m;
         end
      end
      dsq = 0;
      for (int i = 0; i < 3; i++) begin
         diff = 128'(p[i]) - n[i];
         dsq += diff * diff;
      end
      root = root_floor(dsq);
      res.n_x = n[0][31:0];
      res.n_y = n[1][31:0];
      res.n_z = n[2][31:0];
      res.kind = kind;
      res.sat = root > 35'hFFFFFFFF;
      res.distance = res.sat ? 32'hFFFFFFFF : root[31:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      coord_type s[3], e[3], p[3];
      nearest_result_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_mon.distance, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.nearest_x !== want.n_x)
                  report_mismatch("nearest_x", rsp_mon.nearest_x, want.n_x);
               if (rsp_mon.nearest_y !== want.n_y)
                  report_mismatch("nearest_y", rsp_mon.nearest_y, want.n_y);
               if (rsp_mon.nearest_z !== want.n_z)
                  report_mismatch("nearest_z", rsp_mon.nearest_z, want.n_z);
               if (rsp_mon.distance !== want.distance)
                  report_mismatch("distance", rsp_mon.distance, want.distance);
               if (rsp_mon.clamp_kind !== want.kind)
                  report_mismatch("clamp_kind", rsp_mon.clamp_kind, want.kind);
               if (rsp_mon.saturated !== want.sat)
                  report_mismatch("saturated", rsp_mon.saturated, want.sat);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            s = '{req_mon.seg_start_x, req_mon.seg_start_y, req_mon.seg_start_z};
            e = '{req_mon.seg_end_x, req_mon.seg_end_y, req_mon.seg_end_z};
            p = '{req_mon.point_x, req_mon.point_y, req_mon.point_z};
            expected_results.insert(expected_results.size(), project_point(s, e, p));
         end
      end
   end
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the point to segment distance testbench: clock, reset, stimulus
// and verdict. Depends on psd_pkg, psd_channels, the block and psd_checker.
module tb_top;
   import psd_pkg::*;

   localparam int LATENCY     = 76;
   localparam int RANDOM_BEATS = 600;
   // Longest quiet stretch: sender gap plus pipeline latency plus stalls.
   localparam int IDLE_LIMIT  = 2000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   logic stall_mode;

   psd_req_if req_bus ();
   psd_rsp_if rsp_bus ();

   point_segment_distance DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   psd_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The receiver alternates between a steady phase and a stalling phase,
   // each of random length, so backpressure hits every pipeline state.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b1;
         stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
         rsp_bus.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_count);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Random coordinate: mostly modest values so interior projections are
   // common, sometimes any 32-bit word, sometimes an extreme.
   function automatic coord_type pick_coord();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFFFFFF;
         1:       return 32'sh80000000;
         2, 3:    return $urandom();
         default: return coord_type'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
      endcase
   endfunction

   // Drive one request beat and hold it until the block takes it.
   task automatic send_beat(input coord_type s[3], input coord_type e[3],
                            input coord_type p[3]);
      req_bus.valid       <= 1'b1;
      req_bus.seg_start_x <= s[0];
      req_bus.seg_start_y <= s[1];
      req_bus.seg_start_z <= s[2];
      req_bus.seg_end_x   <= e[0];
      req_bus.seg_end_y   <= e[1];
      req_bus.seg_end_z   <= e[2];
      req_bus.point_x     <= p[0];
      req_bus.point_y     <= p[1];
      req_bus.point_z     <= p[2];
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic idle_gap(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   localparam coord_type MAXV = 32'sh7FFFFFFF;
   localparam coord_type MINV = 32'sh80000000;
   localparam coord_type ONE  = 32'sh00010000;

   initial begin
      coord_type s[3], e[3], p[3];
      int burst;
      int drained;
      req_bus.valid <= 1'b0;
      req_bus.seg_start_x <= '0; req_bus.seg_start_y <= '0; req_bus.seg_start_z <= '0;
      req_bus.seg_end_x <= '0;   req_bus.seg_end_y <= '0;   req_bus.seg_end_z <= '0;
      req_bus.point_x <= '0;     req_bus.point_y <= '0;     req_bus.point_z <= '0;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases: interior point, both clamps, degenerate segment,
      // projection landing exactly on either end, 2D work, and extremes
      // that drive the distance into saturation.
      send_beat('{0, 0, 0}, '{4*ONE, 0, 0}, '{ONE, ONE, 0});
      send_beat('{0, 0, 0}, '{4*ONE, 0, 0}, '{-ONE, ONE, 0});
      send_beat('{0, 0, 0}, '{4*ONE, 0, 0}, '{9*ONE, -ONE, 0});
      send_beat('{ONE, 2*ONE, 3*ONE}, '{ONE, 2*ONE, 3*ONE}, '{0, 0, 0});
      send_beat('{0, 0, 0}, '{4*ONE, 0, 0}, '{0, 5*ONE, 0});
      send_beat('{0, 0, 0}, '{4*ONE, 0, 0}, '{4*ONE, 5*ONE, 0});
      send_beat('{ONE, ONE, ONE}, '{-ONE, 3*ONE, 7*ONE}, '{2*ONE, 0, -ONE});
      send_beat('{0, 0, 0}, '{3, 0, 0}, '{1, 7, 0});
      send_beat('{0, 0, 0}, '{3, -5, 7}, '{2, 1, 1});
      send_beat('{MINV, MINV, MINV}, '{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV});
      send_beat('{MAXV, MAXV, MAXV}, '{MAXV, MAXV, MAXV}, '{MINV, MINV, MINV});
      send_beat('{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV}, '{MAXV, MINV, 0});
      send_beat('{MINV, 0, MAXV}, '{MAXV, 0, MINV}, '{MINV, MAXV, MINV});
      send_beat('{MAXV, MINV, MAXV}, '{MINV, MAXV, MINV}, '{0, 0, 0});
      send_beat('{MINV, MINV, 0}, '{MAXV, MAXV, 0}, '{MAXV, MINV, 0});
      send_beat('{-1, -1, -1}, '{1, 1, 1}, '{0, 1, -1});
      send_beat('{0, 0, 0}, '{MAXV, MAXV, MAXV}, '{MINV, MINV, MINV});

      // Random bursts with random gaps; some beats stay 2D.
      for (int n = 0; n < RANDOM_BEATS; ) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && n < RANDOM_BEATS; k++, n++) begin
            for (int i = 0; i < 3; i++) begin
               s[i] = pick_coord();
               e[i] = pick_coord();
               p[i] = pick_coord();
            end
            case ($urandom_range(0, 7))
               0: e = s;                               // zero-length segment
               1: begin s[2] = 0; e[2] = 0; p[2] = 0; end // planar case
               2: p = s;                               // point on the start
               default: ;
            endcase
            send_beat(s, e, p);
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
      req_bus.valid <= 1'b0;

      drained = 0;
      while (pending_count != 0 && drained < IDLE_LIMIT * 4) begin
         @(posedge clock);
         drained++;
      end
      repeat (LATENCY + 10) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

@@ point_segment_distance.f @@
design/psd_pkg.sv
design/psd_channels.sv
design/psd_div.sv
design/psd_sqrt.sv
design/point_segment_distance.sv
verif/psd_checker.sv
verif/tb_top.sv
